// File: hdl/pmv_pkg.sv
package pmv_pkg;

    localparam int GAIN_W     = 16;
    localparam int BAND_W     = 16;
    localparam int LIMIT_W    = 10;
    localparam int VEL_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INTEG_GAIN  = 3'd1,
        REG_DERIV_GAIN  = 3'd2,
        REG_SETTLE_BAND = 3'd3,
        REG_DRIVE_LIMIT = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [BAND_W-1:0]  settle_band;
        logic [LIMIT_W-1:0] drive_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        prop_gain:   16'd192,
        integ_gain:  16'd3,
        deriv_gain:  16'd51,
        settle_band: 16'd50,
        drive_limit: 10'd50
    };

endpackage

// File: hdl/pmv_if.sv
interface pmv_item_if #(
    parameter int POSITION_BITS = 20
) ();
    logic                            valid;
    logic                            ready;
    logic                            cmd;
    logic signed [POSITION_BITS-1:0] goal;
    logic signed [POSITION_BITS-1:0] position;

    modport source (output valid, cmd, goal, position, input ready);
    modport sink (input valid, cmd, goal, position, output ready);
endinterface

interface pmv_res_if import pmv_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VEL_W-1:0] velocity;
    logic                    done_res;

    modport source (output valid, velocity, done_res, input ready);
    modport sink (input valid, velocity, done_res, output ready);
endinterface

interface pmv_cfg_if import pmv_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/pmv_law.sv
module pmv_law import pmv_pkg::*; #(
    parameter int POSITION_BITS  = 20,
    parameter int GAIN_FRAC_BITS = 8,
    parameter int INTEGRAL_BITS  = 24
) (
    input  t_cfg                            i_cfg,
    input  logic signed [POSITION_BITS-1:0] i_goal,
    input  logic signed [POSITION_BITS-1:0] i_position,
    input  logic signed [INTEGRAL_BITS-1:0] i_integ,
    input  logic signed [POSITION_BITS:0]   i_prev,
    output logic signed [POSITION_BITS:0]   o_err,
    output logic signed [INTEGRAL_BITS-1:0] o_integ,
    output logic                            o_in_band,
    output logic signed [VEL_W-1:0]         o_velocity
);

    localparam int EW  = POSITION_BITS + 1;
    localparam int DW  = POSITION_BITS + 2;
    localparam int IB  = INTEGRAL_BITS;
    localparam int SW  = ((IB > EW) ? IB : EW) + 1;
    localparam int MW  = (EW > BAND_W) ? EW : BAND_W;
    localparam int PPW = EW + GAIN_W + 1;
    localparam int PIW = IB + GAIN_W + 1;
    localparam int PDW = DW + GAIN_W + 1;
    localparam int PMX = (PPW > PIW) ? ((PPW > PDW) ? PPW : PDW) : ((PIW > PDW) ? PIW : PDW);
    localparam int AW  = PMX + 2;

    localparam logic signed [SW-1:0] IMAX = {{(SW-IB+1){1'b0}}, {(IB-1){1'b1}}};
    localparam logic signed [SW-1:0] IMIN = {{(SW-IB+1){1'b1}}, {(IB-1){1'b0}}};
    localparam logic [AW-1:0]        BIAS = {{(AW-GAIN_FRAC_BITS){1'b0}},
                                             {GAIN_FRAC_BITS{1'b1}}};

    logic signed [EW-1:0]  err;
    logic [EW-1:0]         mag;
    logic signed [SW-1:0]  sum;
    logic signed [DW-1:0]  deriv;
    logic signed [PPW-1:0] p_prop;
    logic signed [PIW-1:0] p_integ;
    logic signed [PDW-1:0] p_deriv;
    logic signed [AW-1:0]  acc;
    logic signed [AW-1:0]  biased;
    logic signed [AW-1:0]  quot;
    logic signed [AW-1:0]  lim_pos;
    logic signed [AW-1:0]  lim_neg;

    assign err = $signed({i_goal[POSITION_BITS-1], i_goal})
               - $signed({i_position[POSITION_BITS-1], i_position});
    assign mag = err[EW-1] ? (-err) : err;
    assign o_in_band = MW'(mag) <= MW'(i_cfg.settle_band);
    assign o_err = err;

    assign sum = $signed({{(SW-IB){i_integ[IB-1]}}, i_integ})
               + $signed({{(SW-EW){err[EW-1]}}, err});

    always_comb begin
        if (sum > IMAX) begin
            o_integ = IMAX[IB-1:0];
        end else if (sum < IMIN) begin
            o_integ = IMIN[IB-1:0];
        end else begin
            o_integ = sum[IB-1:0];
        end
    end

    assign deriv = $signed({err[EW-1], err}) - $signed({i_prev[EW-1], i_prev});

    assign p_prop  = err * $signed({1'b0, i_cfg.prop_gain});
    assign p_integ = o_integ * $signed({1'b0, i_cfg.integ_gain});
    assign p_deriv = deriv * $signed({1'b0, i_cfg.deriv_gain});

    assign acc = $signed({{(AW-PPW){p_prop[PPW-1]}}, p_prop})
               + $signed({{(AW-PIW){p_integ[PIW-1]}}, p_integ})
               + $signed({{(AW-PDW){p_deriv[PDW-1]}}, p_deriv});

    // Adding the fraction mask to a negative sum makes the shift truncate toward zero.
    assign biased = acc + (acc[AW-1] ? $signed(BIAS) : $signed({AW{1'b0}}));
    assign quot   = biased >>> GAIN_FRAC_BITS;

    assign lim_pos = $signed({{(AW-LIMIT_W){1'b0}}, i_cfg.drive_limit});
    assign lim_neg = -lim_pos;

    always_comb begin
        if (quot > lim_pos) begin
            o_velocity = lim_pos[VEL_W-1:0];
        end else if (quot < lim_neg) begin
            o_velocity = lim_neg[VEL_W-1:0];
        end else begin
            o_velocity = quot[VEL_W-1:0];
        end
    end

endmodule

// File: hdl/pid_position_move.sv
// PID position controller for one move at a time.
// i_item carries words with cmd, goal and position. A word with cmd at the
// start code loads the goal, clears the integral and the previous error,
// and produces no result. A word with cmd at the sample code produces one
// result word on o_res: a velocity clamped to the drive limit, or zero with
// done_res set once the error falls inside the settle band.
// i_cfg writes the gains, settle band and drive limit by register index; it
// is always ready and must be used only while no word is in flight.
// A sample is registered in the input register, and its result word is
// registered in the output register that drives o_res.
// One word is accepted every cycle while o_res does not stall: the input
// register feeds the control law, which updates the state and loads the output
// register in the same cycle, so the next word sees the updated state.
// When o_res stalls, the result holds in the output register and one more
// sample may wait in the input register; start words still pass through.
// Reset clears the pipeline, loads the default gains and leaves the block
// settled, so samples before the first start return zero with done_res set.
module pid_position_move import pmv_pkg::*; #(
    parameter int POSITION_BITS  = 20,
    parameter int GAIN_FRAC_BITS = 8,
    parameter int INTEGRAL_BITS  = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pmv_item_if.sink  i_item,
    pmv_cfg_if.sink   i_cfg,
    pmv_res_if.source o_res
);

    t_cfg r_cfg;

    logic                            r_in_vld;
    logic                            r_in_cmd;
    logic signed [POSITION_BITS-1:0] r_in_goal;
    logic signed [POSITION_BITS-1:0] r_in_pos;

    logic signed [POSITION_BITS-1:0] r_goal;
    logic signed [INTEGRAL_BITS-1:0] r_integ;
    logic signed [POSITION_BITS:0]   r_prev;
    logic                            r_settled;

    logic                            r_out_vld;
    logic signed [VEL_W-1:0]         r_out_vel;
    logic                            r_out_done;

    logic                            n_out_vld;
    logic                            w_has_res;
    logic                            w_adv;
    logic                            w_take;
    logic signed [POSITION_BITS:0]   w_err;
    logic signed [INTEGRAL_BITS-1:0] w_integ;
    logic                            w_in_band;
    logic signed [VEL_W-1:0]         w_vel;

    pmv_law #(
        .POSITION_BITS  (POSITION_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .INTEGRAL_BITS  (INTEGRAL_BITS)
    ) u_law (
        .i_cfg      (r_cfg),
        .i_goal     (r_goal),
        .i_position (r_in_pos),
        .i_integ    (r_integ),
        .i_prev     (r_prev),
        .o_err      (w_err),
        .o_integ    (w_integ),
        .o_in_band  (w_in_band),
        .o_velocity (w_vel)
    );

    assign w_has_res    = r_in_cmd == CMD_SAMPLE;
    assign w_adv        = r_in_vld && (!w_has_res || !r_out_vld || o_res.ready);
    assign i_item.ready = !r_in_vld || w_adv;
    assign w_take       = i_item.valid && i_item.ready;
    assign i_cfg.ready  = 1'b1;

    assign o_res.valid    = r_out_vld;
    assign o_res.velocity = r_out_vel;
    assign o_res.done_res = r_out_done;

    always_comb begin
        if (w_adv && w_has_res) begin
            n_out_vld = 1'b1;
        end else if (o_res.ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_PROP_GAIN:   r_cfg.prop_gain   <= i_cfg.data;
                REG_INTEG_GAIN:  r_cfg.integ_gain  <= i_cfg.data;
                REG_DERIV_GAIN:  r_cfg.deriv_gain  <= i_cfg.data;
                REG_SETTLE_BAND: r_cfg.settle_band <= i_cfg.data;
                REG_DRIVE_LIMIT: r_cfg.drive_limit <= i_cfg.data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_take) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_cmd  <= i_item.cmd;
            r_in_goal <= i_item.goal;
            r_in_pos  <= i_item.position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal    <= '0;
            r_integ   <= '0;
            r_prev    <= '0;
            r_settled <= 1'b1;
        end else if (w_adv) begin
            if (!w_has_res) begin
                r_goal    <= r_in_goal;
                r_integ   <= '0;
                r_prev    <= '0;
                r_settled <= 1'b0;
            end else if (!r_settled) begin
                if (w_in_band) begin
                    r_settled <= 1'b1;
                end else begin
                    r_integ <= w_integ;
                    r_prev  <= w_err;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_has_res) begin
            if (r_settled || w_in_band) begin
                r_out_vel  <= '0;
                r_out_done <= 1'b1;
            end else begin
                r_out_vel  <= w_vel;
                r_out_done <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_vel_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_vel <= $signed({1'b0, r_cfg.drive_limit})) &&
                      (r_out_vel >= -$signed({1'b0, r_cfg.drive_limit})))
        else $error("Velocity result exceeds the drive limit.");

    a_done_zero_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_done) |-> (r_out_vel == '0))
        else $error("Settled result carries a nonzero velocity.");

    a_unsettle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_settled) |-> $past(w_adv && (r_in_cmd == CMD_START)))
        else $error("Settled flag cleared without a start word.");
`endif

endmodule

// File: test/tb_pid_position_move.sv
`timescale 1ns / 1ps

module tb_pid_position_move import pmv_pkg::*;;

    localparam int POS_W       = 20;
    localparam int FRAC_W      = 8;
    localparam int INTEG_W     = 24;
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        logic                    cmd;
        logic signed [POS_W-1:0] goal;
        logic signed [POS_W-1:0] position;
    } t_move_word;

    typedef struct packed {
        logic signed [VEL_W-1:0] velocity;
        logic                    done_res;
    } t_drive_cmd;

    logic i_clk;
    logic i_rst_n;

    pmv_item_if #(.POSITION_BITS(POS_W)) item_bus ();
    pmv_cfg_if cfg_bus ();
    pmv_res_if res_bus ();

    pid_position_move #(
        .POSITION_BITS (POS_W),
        .GAIN_FRAC_BITS(FRAC_W),
        .INTEGRAL_BITS (INTEG_W)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (item_bus),
        .i_cfg  (cfg_bus),
        .o_res  (res_bus)
    );

    t_move_word words_to_send[$];
    t_drive_cmd velocity_due[$];

    t_cfg                    gains_now;
    logic signed [POS_W-1:0] target_pos;
    longint                  integ_acc;
    longint                  last_err;
    logic                    at_rest;

    int src_idle_pct;
    int sink_stall_pct;
    int hold_off_cycles;
    bit sender_paused;
    int bad_words;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void advance_controller(input logic cmd,
                                               input logic signed [POS_W-1:0] goal,
                                               input logic signed [POS_W-1:0] pos);
        longint err;
        longint mag;
        longint deriv;
        longint acc;
        longint vel;
        longint lim;
        t_drive_cmd res;
        if (cmd == CMD_START) begin
            target_pos = goal;
            integ_acc  = 0;
            last_err   = 0;
            at_rest    = 1'b0;
            return;
        end
        res.velocity = '0;
        res.done_res = 1'b1;
        if (at_rest) begin
            velocity_due.push_back(res);
            return;
        end
        err = longint'(target_pos) - longint'(pos);
        mag = (err < 0) ? -err : err;
        if (mag <= longint'(gains_now.settle_band)) begin
            at_rest = 1'b1;
            velocity_due.push_back(res);
            return;
        end
        lim = longint'(1) << (INTEG_W - 1);
        integ_acc = integ_acc + err;
        if (integ_acc > lim - 1) integ_acc = lim - 1;
        if (integ_acc < -lim) integ_acc = -lim;
        deriv    = err - last_err;
        last_err = err;
        acc = longint'(gains_now.prop_gain) * err
            + longint'(gains_now.integ_gain) * integ_acc
            + longint'(gains_now.deriv_gain) * deriv;
        vel = acc / (longint'(1) << FRAC_W);
        if (vel > longint'(gains_now.drive_limit)) vel = longint'(gains_now.drive_limit);
        if (vel < -longint'(gains_now.drive_limit)) vel = -longint'(gains_now.drive_limit);
        res.velocity = vel[VEL_W-1:0];
        res.done_res = 1'b0;
        velocity_due.push_back(res);
    endfunction

    function automatic void report_bad(input string why, input t_drive_cmd want,
                                       input t_drive_cmd got);
        if (bad_words < 10) begin
            $display("%0t: %s: expected velocity %0d done %0b, got velocity %0d done %0b",
                     $time, why, want.velocity, want.done_res, got.velocity, got.done_res);
        end
        bad_words++;
    endfunction

    // The driver predicts each word at the edge that accepts it.
    always @(posedge i_clk) begin
        t_move_word w;
        if (!i_rst_n) begin
            item_bus.valid <= 1'b0;
        end else begin
            if (item_bus.valid && item_bus.ready) begin
                advance_controller(item_bus.cmd, item_bus.goal, item_bus.position);
            end
            if (!item_bus.valid || item_bus.ready) begin
                if (words_to_send.size() != 0 && !sender_paused &&
                    $urandom_range(99) >= src_idle_pct) begin
                    w = words_to_send.pop_front();
                    item_bus.valid    <= 1'b1;
                    item_bus.cmd      <= w.cmd;
                    item_bus.goal     <= w.goal;
                    item_bus.position <= w.position;
                end else begin
                    item_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_drive_cmd got;
        t_drive_cmd want;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                got.velocity = res_bus.velocity;
                got.done_res = res_bus.done_res;
                if (velocity_due.size() == 0) begin
                    want = '0;
                    report_bad("unexpected word", want, got);
                end else begin
                    want = velocity_due.pop_front();
                    if (got.velocity !== want.velocity || got.done_res !== want.done_res) begin
                        report_bad("mismatch", want, got);
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (item_bus.valid && item_bus.ready) ||
            (res_bus.valid && res_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic void push_word(input logic cmd, input logic signed [POS_W-1:0] goal,
                                      input logic signed [POS_W-1:0] pos);
        t_move_word w;
        w.cmd      = cmd;
        w.goal     = goal;
        w.position = pos;
        words_to_send.push_back(w);
    endfunction

    // A move is a start followed by samples that close in on the target.
    function automatic int queue_move(input int samples);
        logic signed [POS_W-1:0] tgt;
        logic signed [POS_W-1:0] offset;
        int span;
        int k;
        tgt = POS_W'($urandom);
        push_word(CMD_START, tgt, POS_W'($urandom));
        case ($urandom_range(3))
            0: span = 64;
            1: span = 4096;
            2: span = 200000;
            default: span = 1 << POS_W;
        endcase
        for (k = 0; k < samples; k++) begin
            offset = POS_W'(int'($urandom_range(2 * span)) - span);
            push_word(CMD_SAMPLE, POS_W'($urandom), tgt - offset);
            span = (span * 3) / 4 + 1;
        end
        return samples + 1;
    endfunction

    task automatic fill_random(input int count);
        int added;
        added = 0;
        while (added < count) begin
            if ($urandom_range(9) == 0) begin
                push_word(1'($urandom), POS_W'($urandom), POS_W'($urandom));
                added++;
            end else begin
                added += queue_move($urandom_range(1, 16));
            end
        end
    endtask

    task automatic wait_drained();
        while (words_to_send.size() != 0 || item_bus.valid || velocity_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (idx)
            REG_PROP_GAIN:   gains_now.prop_gain   = val;
            REG_INTEG_GAIN:  gains_now.integ_gain  = val;
            REG_DERIV_GAIN:  gains_now.deriv_gain  = val;
            REG_SETTLE_BAND: gains_now.settle_band = val;
            REG_DRIVE_LIMIT: gains_now.drive_limit = val[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic program_gains(input logic [15:0] kp, input logic [15:0] ki,
                                 input logic [15:0] kd, input logic [15:0] band,
                                 input logic [15:0] limit);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_DERIV_GAIN, kd);
        write_reg(REG_SETTLE_BAND, band);
        write_reg(REG_DRIVE_LIMIT, limit);
    endtask

    task automatic run_phase(input int count, input int src_pct, input int sink_pct);
        @(negedge i_clk);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        fill_random(count);
        wait_drained();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        item_bus.valid    = 1'b0;
        item_bus.cmd      = CMD_START;
        item_bus.goal     = '0;
        item_bus.position = '0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = REG_PROP_GAIN;
        cfg_bus.data      = '0;
        res_bus.ready     = 1'b0;
        gains_now         = CFG_RESET;
        target_pos        = '0;
        integ_acc         = 0;
        last_err          = 0;
        at_rest           = 1'b1;
        src_idle_pct      = 0;
        sink_stall_pct    = 0;
        hold_off_cycles   = 0;
        sender_paused     = 1'b0;
        bad_words         = 0;
        quiet_cycles      = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Samples before any start find the controller settled.
        push_word(CMD_SAMPLE, POS_W'($urandom), POS_W'(-524288));
        push_word(CMD_SAMPLE, POS_W'($urandom), POS_W'(524287));
        push_word(CMD_START, POS_W'(0), POS_W'($urandom));
        push_word(CMD_SAMPLE, POS_W'($urandom), POS_W'(0));
        push_word(CMD_SAMPLE, POS_W'($urandom), POS_W'(524287));
        // Largest positive error, held long enough to saturate the integral.
        push_word(CMD_START, POS_W'(524287), POS_W'($urandom));
        repeat (10) push_word(CMD_SAMPLE, POS_W'($urandom), POS_W'(-524288));
        push_word(CMD_SAMPLE, POS_W'($urandom), POS_W'(524287));
        push_word(CMD_START, POS_W'(-524288), POS_W'($urandom));
        push_word(CMD_SAMPLE, POS_W'($urandom), POS_W'(524287));
        push_word(CMD_SAMPLE, POS_W'($urandom), POS_W'(524287));
        // Errors just outside and exactly on the settle band.
        push_word(CMD_START, POS_W'(100), POS_W'($urandom));
        push_word(CMD_SAMPLE, POS_W'($urandom), POS_W'(49));
        push_word(CMD_SAMPLE, POS_W'($urandom), POS_W'(50));
        push_word(CMD_START, POS_W'(100), POS_W'($urandom));
        push_word(CMD_SAMPLE, POS_W'($urandom), POS_W'(150));
        wait_drained();

        run_phase(130, 0, 0);

        program_gains(16'($urandom_range(1024)), 16'($urandom_range(64)),
                      16'($urandom_range(512)), 16'($urandom_range(200)), 16'($urandom));
        run_phase(110, 51, 0);

        program_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
        run_phase(110, 0, 51);

        program_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h03FF);
        run_phase(100, 12, 12);

        // A drive limit of zero pins the velocity at zero.
        program_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'hFFFF, 16'hFC00);
        run_phase(100, 51, 51);

        program_gains(16'($urandom), 16'($urandom_range(300)), 16'($urandom),
                      16'($urandom_range(300)), 16'($urandom));
        run_phase(130, 12, 12);

        program_gains(CFG_RESET.prop_gain, CFG_RESET.integ_gain, CFG_RESET.deriv_gain,
                      CFG_RESET.settle_band, 16'(CFG_RESET.drive_limit));
        @(negedge i_clk);
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        hold_off_cycles = LONG_HOLD;
        fill_random(130);
        while (words_to_send.size() > 60) @(negedge i_clk);
        sender_paused = 1'b1;
        while (velocity_due.size() != 0 || item_bus.valid) @(negedge i_clk);
        sender_paused = 1'b0;
        wait_drained();

        repeat (10) @(negedge i_clk);
        if (bad_words == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
